// ===== design/st_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// st_pkg
// Types, token codes, keyword table and character classes for the tokenizer.
// ----------------------------------------------------------------------------
package st_pkg;

    localparam int MAX_IDENT   = 32;
    localparam int IDX_W       = $clog2(MAX_IDENT);
    localparam int LEN_W       = $clog2(MAX_IDENT + 1);
    localparam int NUM_KW      = 19;
    localparam int KW_MAX_LEN  = 7;

    localparam logic [5:0] K_ERROR = 6'd0;
    localparam logic [5:0] K_END   = 6'd1;
    localparam logic [5:0] K_INT   = 6'd2;
    localparam logic [5:0] K_REAL  = 6'd3;
    localparam logic [5:0] K_BOOL  = 6'd4;
    localparam logic [5:0] K_ICHAR = 6'd5;
    localparam logic [5:0] K_SCHAR = 6'd6;
    localparam logic [5:0] K_SEND  = 6'd7;
    localparam logic [5:0] K_PLUS  = 6'd8;
    localparam logic [5:0] K_MINUS = 6'd9;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_NO_MATCH = 3'd1;
    localparam logic [2:0] E_ESCAPE   = 3'd2;
    localparam logic [2:0] E_UNTERM   = 3'd3;
    localparam logic [2:0] E_EXP_DIG  = 3'd4;
    localparam logic [2:0] E_LONG_ID  = 3'd5;

    // keyword text, right-justified, first character in the highest used byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_WORD [NUM_KW] = '{
        "and", "assign", "bool", "cos", "false", "if", "iff", "int", "let",
        "logn", "not", "or", "println", "real", "sin", "string", "tan",
        "true", "while"
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd6, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd3, 3'd2, 3'd7, 3'd4, 3'd3, 3'd6, 3'd3, 3'd4, 3'd5
    };
    localparam logic [5:0] KW_KIND [NUM_KW] = '{
        6'd18, 6'd19, 6'd20, 6'd21, K_BOOL, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, K_BOOL, 6'd34
    };
    localparam logic KW_VAL [NUM_KW] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
    };

    typedef enum logic [3:0] {
        M_IDLE, M_SIGN, M_INT, M_FRAC, M_EXP_E, M_EXP_SIGN, M_EXP_DIG,
        M_IDENT, M_STR, M_STR_ESC, M_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        S_IN, S_PROC, S_CMP, S_KW, S_EMIT
    } t_seq;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        logic [5:0]         token_kind;
        logic [7:0]         text_char;
        logic signed [31:0] number_value;
        logic signed [11:0] decimal_exponent;
        logic               token_done;
        logic [2:0]         error_code;
        logic [15:0]        line_number;
        logic               last;
    } t_out_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_mem_wr;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == "*") || (c == "/") || (c == "%") || (c == "^") ||
               (c == "=") || (c == "<") || (c == "(") || (c == ")");
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "*":     k = 6'd10;
            "/":     k = 6'd11;
            "%":     k = 6'd12;
            "^":     k = 6'd13;
            "=":     k = 6'd14;
            "<":     k = 6'd15;
            "(":     k = 6'd16;
            ")":     k = 6'd17;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // does a new token starting with c produce a request right away
    function automatic logic starts_result(input logic [7:0] c);
        return !((c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == "+") ||
                 (c == "-") || is_word(c) || (c == "'") || (c == 8'h22));
    endfunction

    function automatic logic [8:0] escape_of(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h5C:   r = {1'b1, 8'h5C};
            "'":     r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            "0":     r = {1'b1, 8'h00};
            "n":     r = {1'b1, 8'h0A};
            "r":     r = {1'b1, 8'h0D};
            "t":     r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [IDX_W-1:0] pos);
        int s;
        s = int'(KW_LEN[k]) - 1 - int'(pos);
        if (s < 0 || s >= KW_MAX_LEN) return 8'd0;
        return KW_WORD[k][s*8 +: 8];
    endfunction

endpackage

// ===== design/source_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_top
// Streaming tokenizer: one source byte per request in, token requests out.
//
//  channel | dir | handshake            | payload
//  in      | in  | i_valid / o_stall    | i_in  (t_in_req)
//  out     | out | o_valid / i_stall    | o_out (t_out_req)
//
// A byte is accepted, then processed. A byte that ends a number or operator
// sign is processed once more for the flush.
// Ending an identifier of n chars walks the buffer through its single read
// port: a keyword compare over its characters and a step that reports a match
// (only for n <= 7), then streaming its characters if no keyword matched,
// and a final pass that processes the ending byte.
// Reset is synchronous; no clearing pass is needed. A stalled output holds
// the processing sequencer; the input stays stalled until the byte is done.
// ----------------------------------------------------------------------------
module source_tokenizer_top
    import st_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_in,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_out
);

    t_seq  r_state, n_state;
    t_mode r_mode,  n_mode;
    logic [7:0]        r_ch, n_ch;
    logic              r_eoi, n_eoi;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [31:0]       r_acc, n_acc;
    logic [11:0]       r_fd, n_fd;
    logic [11:0]       r_ea, n_ea;
    logic              r_neg, n_neg;
    logic              r_eneg, n_eneg;
    logic [7:0]        r_delim, n_delim;
    logic [15:0]       r_line, n_line;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_dv, n_dv;
    logic [NUM_KW-1:0] r_cand, n_cand;
    logic              r_ovalid;
    t_out_req          r_out;

    logic              slot_free, in_acc, emit, flush_last, last_pos;
    t_out_req          res;
    t_mem_wr           wr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [7:0]        rd_data;
    logic [NUM_KW-1:0] match_vec, len_vec;
    logic [3:0]        digit;
    logic [15:0]       ea_next;
    logic signed [13:0] e_full;
    logic [11:0]       e_sat;
    logic [31:0]       num_val;
    logic [8:0]        esc;
    logic [5:0]        kw_kind_sel;
    logic              kw_val_sel;

    st_ident_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign slot_free = !r_ovalid || !i_stall;
    assign o_stall   = (r_state != S_IN);
    assign in_acc    = i_valid && !o_stall;
    assign o_valid   = r_ovalid;
    assign o_out     = r_out;

    assign digit      = r_ch[3:0];
    assign flush_last = r_eoi ? 1'b0 : !starts_result(r_ch);
    assign last_pos   = (LEN_W'(r_idx) == (r_len - LEN_W'(1)));
    assign num_val    = r_neg ? (32'd0 - r_acc) : r_acc;
    assign ea_next    = ({4'd0, r_ea} << 3) + ({4'd0, r_ea} << 1) + {12'd0, digit};
    assign esc        = escape_of(r_ch);

    always_comb begin
        e_full = r_eneg ? -$signed({2'b00, r_ea}) : $signed({2'b00, r_ea});
        e_full = e_full - $signed({2'b00, r_fd});
        if (e_full > 14'sd2047) begin
            e_sat = 12'h7FF;
        end else if (e_full < -14'sd2048) begin
            e_sat = 12'h800;
        end else begin
            e_sat = e_full[11:0];
        end
    end

    always_comb begin
        kw_kind_sel = K_ERROR;
        kw_val_sel  = 1'b0;
        for (int k = 0; k < NUM_KW; k++) begin
            match_vec[k] = (kw_char(k, r_idx) == rd_data);
            len_vec[k]   = (LEN_W'(KW_LEN[k]) == r_len);
            if (r_cand[k]) begin
                kw_kind_sel = KW_KIND[k];
                kw_val_sel  = KW_VAL[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;  n_mode = r_mode;  n_ch = r_ch;  n_eoi = r_eoi;
        n_len = r_len;  n_acc = r_acc;  n_fd = r_fd;  n_ea = r_ea;
        n_neg = r_neg;  n_eneg = r_eneg;  n_delim = r_delim;  n_line = r_line;
        n_idx = r_idx;  n_dv = r_dv;  n_cand = r_cand;
        emit = 1'b0;
        res = '0;
        res.line_number = r_line;
        wr.en = 1'b0;  wr.addr = r_len[IDX_W-1:0];  wr.data = r_ch;
        rd_en = 1'b0;  rd_addr = r_idx;

        case (r_state)
            S_IN: begin
                if (in_acc) begin
                    n_ch    = i_in.char_code;
                    n_eoi   = i_in.end_of_input;
                    n_state = S_PROC;
                end
            end

            S_PROC: begin
                if (slot_free) begin
                    if (r_eoi) begin
                        case (r_mode)
                            M_SIGN: begin
                                emit = 1'b1;
                                res.token_kind = r_neg ? K_MINUS : K_PLUS;
                                res.token_done = 1'b1;
                                n_mode = M_IDLE;
                            end
                            M_INT, M_FRAC, M_EXP_DIG: begin
                                emit = 1'b1;
                                res.token_kind = (r_mode == M_INT) ? K_INT : K_REAL;
                                res.number_value = num_val;
                                res.decimal_exponent = (r_mode == M_INT) ? 12'd0 : e_sat;
                                res.token_done = 1'b1;
                                n_mode = M_IDLE;
                            end
                            M_EXP_E, M_EXP_SIGN: begin
                                emit = 1'b1;
                                res.token_done = 1'b1;
                                res.error_code = E_EXP_DIG;
                                n_mode = M_ERROR;
                            end
                            M_STR, M_STR_ESC: begin
                                emit = 1'b1;
                                res.token_done = 1'b1;
                                res.error_code = E_UNTERM;
                                n_mode = M_ERROR;
                            end
                            M_IDENT: begin
                                n_idx = '0;
                                n_dv  = 1'b0;
                                n_cand = len_vec;
                                n_state = (r_len <= LEN_W'(KW_MAX_LEN)) ? S_CMP : S_EMIT;
                            end
                            default: begin
                                // end request, then everything back to reset values
                                emit = 1'b1;
                                res.token_kind = K_END;
                                res.token_done = 1'b1;
                                res.last = 1'b1;
                                n_mode = M_IDLE;  n_len = '0;  n_acc = '0;  n_fd = '0;
                                n_ea = '0;  n_neg = 1'b0;  n_eneg = 1'b0;
                                n_delim = '0;  n_line = 16'd1;
                                n_state = S_IN;
                            end
                        endcase
                    end else begin
                        n_state = S_IN;
                        case (r_mode)
                            M_ERROR: begin
                            end
                            M_SIGN: begin
                                if (is_digit(r_ch)) begin
                                    n_acc = {28'd0, digit};
                                    n_fd = '0;  n_ea = '0;  n_eneg = 1'b0;
                                    n_mode = M_INT;
                                end else begin
                                    emit = 1'b1;
                                    res.token_kind = r_neg ? K_MINUS : K_PLUS;
                                    res.token_done = 1'b1;
                                    res.last = flush_last;
                                    n_mode = M_IDLE;
                                    n_state = S_PROC;
                                end
                            end
                            M_INT, M_FRAC, M_EXP_DIG: begin
                                if (is_digit(r_ch) && r_mode == M_EXP_DIG) begin
                                    n_ea = (ea_next > 16'd4095) ? 12'd4095 : ea_next[11:0];
                                end else if (is_digit(r_ch)) begin
                                    n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, digit};
                                    if (r_mode == M_FRAC && r_fd != 12'd4095) begin
                                        n_fd = r_fd + 12'd1;
                                    end
                                end else if (r_ch == "." && r_mode == M_INT) begin
                                    n_mode = M_FRAC;
                                end else if (r_ch == "e" && r_mode != M_EXP_DIG) begin
                                    n_mode = M_EXP_E;
                                end else begin
                                    emit = 1'b1;
                                    res.token_kind = (r_mode == M_INT) ? K_INT : K_REAL;
                                    res.number_value = num_val;
                                    res.decimal_exponent = (r_mode == M_INT) ? 12'd0 : e_sat;
                                    res.token_done = 1'b1;
                                    res.last = flush_last;
                                    n_mode = M_IDLE;
                                    n_state = S_PROC;
                                end
                            end
                            M_EXP_E, M_EXP_SIGN: begin
                                if (r_mode == M_EXP_E && (r_ch == "+" || r_ch == "-")) begin
                                    n_eneg = (r_ch == "-");
                                    n_mode = M_EXP_SIGN;
                                end else if (is_digit(r_ch)) begin
                                    n_ea = {8'd0, digit};
                                    n_mode = M_EXP_DIG;
                                end else begin
                                    emit = 1'b1;
                                    res.token_done = 1'b1;
                                    res.error_code = E_EXP_DIG;
                                    res.last = 1'b1;
                                    n_mode = M_ERROR;
                                end
                            end
                            M_IDENT: begin
                                if (is_word(r_ch)) begin
                                    if (r_len >= LEN_W'(MAX_IDENT)) begin
                                        emit = 1'b1;
                                        res.token_done = 1'b1;
                                        res.error_code = E_LONG_ID;
                                        res.last = 1'b1;
                                        n_mode = M_ERROR;
                                    end else begin
                                        wr.en = 1'b1;
                                        n_len = r_len + LEN_W'(1);
                                    end
                                end else begin
                                    n_idx = '0;
                                    n_dv  = 1'b0;
                                    n_cand = len_vec;
                                    n_state = (r_len <= LEN_W'(KW_MAX_LEN)) ? S_CMP : S_EMIT;
                                end
                            end
                            M_STR: begin
                                if (r_ch == r_delim) begin
                                    emit = 1'b1;
                                    res.token_kind = K_SEND;
                                    res.token_done = 1'b1;
                                    res.last = 1'b1;
                                    n_mode = M_IDLE;
                                end else if (r_ch == 8'h5C) begin
                                    n_mode = M_STR_ESC;
                                end else begin
                                    emit = 1'b1;
                                    res.token_kind = K_SCHAR;
                                    res.text_char = r_ch;
                                    res.last = 1'b1;
                                end
                            end
                            M_STR_ESC: begin
                                emit = 1'b1;
                                res.last = 1'b1;
                                if (esc[8]) begin
                                    res.token_kind = K_SCHAR;
                                    res.text_char = esc[7:0];
                                    n_mode = M_STR;
                                end else begin
                                    res.token_done = 1'b1;
                                    res.error_code = E_ESCAPE;
                                    n_mode = M_ERROR;
                                end
                            end
                            default: begin
                                // between tokens: start a new one
                                n_mode = M_IDLE;
                                if (r_ch == 8'h0A) begin
                                    if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                                end else if (r_ch == "+" || r_ch == "-") begin
                                    n_neg = (r_ch == "-");
                                    n_mode = M_SIGN;
                                end else if (is_op(r_ch)) begin
                                    emit = 1'b1;
                                    res.token_kind = op_kind(r_ch);
                                    res.token_done = 1'b1;
                                    res.last = 1'b1;
                                end else if (is_digit(r_ch)) begin
                                    n_neg = 1'b0;
                                    n_acc = {28'd0, digit};
                                    n_fd = '0;  n_ea = '0;  n_eneg = 1'b0;
                                    n_mode = M_INT;
                                end else if (is_word(r_ch)) begin
                                    wr.en = 1'b1;
                                    wr.addr = '0;
                                    n_len = LEN_W'(1);
                                    n_mode = M_IDENT;
                                end else if (r_ch == "'" || r_ch == 8'h22) begin
                                    n_delim = r_ch;
                                    n_mode = M_STR;
                                end else if (r_ch != " " && r_ch != 8'h09) begin
                                    emit = 1'b1;
                                    res.token_done = 1'b1;
                                    res.error_code = E_NO_MATCH;
                                    res.last = 1'b1;
                                    n_mode = M_ERROR;
                                end
                            end
                        endcase
                    end
                end
            end

            S_CMP: begin
                if (!r_dv) begin
                    rd_en = 1'b1;
                    n_dv = 1'b1;
                end else begin
                    n_cand = r_cand & match_vec;
                    if (last_pos) begin
                        n_dv = 1'b0;
                        n_state = S_KW;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = r_idx + IDX_W'(1);
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            S_KW: begin
                if (|r_cand) begin
                    if (slot_free) begin
                        emit = 1'b1;
                        res.token_kind = kw_kind_sel;
                        res.number_value = {31'd0, kw_val_sel};
                        res.token_done = 1'b1;
                        res.last = flush_last;
                        n_mode = M_IDLE;
                        n_state = S_PROC;
                    end
                end else begin
                    n_idx = '0;
                    n_dv = 1'b0;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (!r_dv) begin
                    rd_en = 1'b1;
                    n_dv = 1'b1;
                end else if (slot_free) begin
                    emit = 1'b1;
                    res.token_kind = K_ICHAR;
                    res.text_char = rd_data;
                    res.token_done = last_pos;
                    res.last = last_pos && flush_last;
                    if (last_pos) begin
                        n_dv = 1'b0;
                        n_mode = M_IDLE;
                        n_state = S_PROC;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = r_idx + IDX_W'(1);
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_mode  <= M_IDLE;
            r_len   <= '0;
            r_acc   <= '0;
            r_fd    <= '0;
            r_ea    <= '0;
            r_neg   <= 1'b0;
            r_eneg  <= 1'b0;
            r_delim <= '0;
            r_line  <= 16'd1;
            r_dv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_fd    <= n_fd;
            r_ea    <= n_ea;
            r_neg   <= n_neg;
            r_eneg  <= n_eneg;
            r_delim <= n_delim;
            r_line  <= n_line;
            r_dv    <= n_dv;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_eoi  <= n_eoi;
        r_idx  <= n_idx;
        r_cand <= n_cand;
        if (emit) begin
            r_out <= res;
        end
    end

`ifndef SYNTH
    a_cmp_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_len <= LEN_W'(KW_MAX_LEN)))
        else $error("keyword compare on a long identifier");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_IDENT))
        else $error("identifier length overflow");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.error_code != E_NONE) |-> (r_out.token_kind == K_ERROR))
        else $error("error code on a non-error token");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PROC))
        else $error("accepted byte not processed");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot_free)
        else $error("request overwrites a held output");
`endif

endmodule

// ===== design/st_ident_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// st_ident_mem
// Identifier character buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module st_ident_mem
    import st_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data
);

    logic [7:0] r_mem [MAX_IDENT];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
